@@ rtl/core/itw_pkg.sv @@
// Package for the inactivity timeout watchdog: transaction structs, event codes
// and fixed constants of the seconds conversion.
// No dependencies; used by inactivity_timeout_with_warning_top.
package itw_pkg;

    // Event codes reported with every result.
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_CLEAR = 2'd1;
    localparam logic [1:0] EV_SHOW  = 2'd2;
    localparam logic [1:0] EV_OFF   = 2'd3;

    localparam int MINUTES_W = 11;
    localparam int MS_W      = 27;
    localparam int NOW_W     = 32;
    localparam int SECS_W    = 6;
    localparam int SHOWN_W   = 7;

    localparam logic [MS_W-1:0]    MS_PER_MINUTE = 27'd60000;
    localparam logic [SHOWN_W-1:0] NO_SECONDS    = 7'd127;
    localparam logic [SHOWN_W-1:0] SECS_CAP      = 7'd63;

    // Rounded-up seconds: floor((x + 999) / 1000) by reciprocal multiply.
    // The reciprocal ceil(2^30 / 1000) is exact for inputs below 2^20,
    // which covers any warning window up to 600 s.
    localparam int DIV_IN_W    = 20;
    localparam int DIV_RECIP_W = 21;
    localparam int DIV_SHIFT   = 30;
    localparam int DIV_PROD_W  = DIV_IN_W + DIV_RECIP_W;
    localparam int DIV_Q_W     = DIV_PROD_W - DIV_SHIFT;
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 21'd1073742;
    localparam logic [DIV_IN_W-1:0]    ROUND_UP  = 20'd999;

    // One loop pass.
    typedef struct packed {
        logic [NOW_W-1:0] now_ms;
        logic             activity;
        logic             scene_active;
    } item_t;

    // One watchdog result.
    typedef struct packed {
        logic [1:0]        event_res;
        logic [SECS_W-1:0] seconds_left;
        logic              flash_invert;
        logic [MS_W-1:0]   time_left_ms;
        logic [MS_W-1:0]   window_ms;
        logic              status_valid;
    } result_t;

endpackage

@@ rtl/core/inactivity_timeout_with_warning_top.sv @@
// Inactivity watchdog with warning countdown: top level.
// Depends on itw_pkg for the transaction structs, event codes and constants.
//
// Each transaction on the item channel is one loop pass (timestamp, activity,
// scene-active) and yields exactly one result transaction. The block takes one
// transaction per cycle while item_stall is low, and its path to the result is:
// the pass sits in an input register, then one pass of compare, subtract and
// reciprocal multiply updates the watchdog state and fills the result register.
// That state update is what sets the rate. The timeout register is
// written through cfg_valid/cfg_data while the block is idle; cfg_ready is low
// while a pass waits in the input register, the value is clamped to
// MIN_MINUTES..MAX_MINUTES, and the derived total and warning threshold apply
// to the next pass.
module inactivity_timeout_with_warning_top #(
    parameter int MIN_MINUTES = 1,
    parameter int MAX_MINUTES = 1440,
    parameter int WARN_MS     = 60000
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  itw_pkg::item_t                     item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output itw_pkg::result_t                   result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [itw_pkg::MINUTES_W-1:0]      cfg_data
);

    localparam int MS_W    = itw_pkg::MS_W;
    localparam int NOW_W   = itw_pkg::NOW_W;
    localparam int SHOWN_W = itw_pkg::SHOWN_W;

    localparam logic [itw_pkg::MINUTES_W-1:0] MIN_M = itw_pkg::MINUTES_W'(MIN_MINUTES);
    localparam logic [itw_pkg::MINUTES_W-1:0] MAX_M = itw_pkg::MINUTES_W'(MAX_MINUTES);
    localparam logic [MS_W-1:0] WARN_V = MS_W'(WARN_MS);

    // Reset timeout is 60 minutes.
    localparam int RESET_TOTAL_I  = 60 * 60000;
    localparam int RESET_WARN_I   = (WARN_MS >= RESET_TOTAL_I) ? RESET_TOTAL_I / 2 : WARN_MS;
    localparam logic [MS_W-1:0] RESET_TOTAL  = MS_W'(RESET_TOTAL_I);
    localparam logic [MS_W-1:0] RESET_THRESH = MS_W'(RESET_TOTAL_I - RESET_WARN_I);

    // Configuration-derived registers.
    logic [MS_W-1:0] total_reg, total_next;
    logic [MS_W-1:0] thresh_reg, thresh_next;

    // Watchdog state.
    logic [NOW_W-1:0]   last_act_reg, last_act_next;
    logic               seeded_reg, seeded_next;
    logic               showing_reg, showing_next;
    logic [SHOWN_W-1:0] shown_reg, shown_next;

    // Pipeline registers.
    logic             s1_valid_reg, s1_valid_next;
    itw_pkg::item_t   s1_data_reg, s1_data_next;
    logic             res_valid_reg, res_valid_next;
    itw_pkg::result_t res_data_reg, res_data_next;

    logic advance;
    logic load_in;
    logic process;
    logic cfg_write;

    // Handshake: the pipe moves when the result register is free or taken; an
    // empty input register loads too. A timeout write waits until no pass is left.
    assign advance    = !res_valid_reg || !result_stall;
    assign load_in    = !s1_valid_reg || advance;
    assign process    = s1_valid_reg && advance;
    assign item_stall = !load_in;
    assign cfg_ready  = !s1_valid_reg;
    assign cfg_write  = cfg_valid && cfg_ready;

    assign result_valid = res_valid_reg;
    assign result       = res_data_reg;

    // Configuration write: clamp, scale to ms, derive the warning threshold.
    logic [itw_pkg::MINUTES_W-1:0] cfg_min;
    logic [MS_W-1:0]               cfg_total;
    logic [MS_W-1:0]               cfg_warn;

    always_comb
    begin
        if (cfg_data < MIN_M)
        begin
            cfg_min = MIN_M;
        end
        else if (cfg_data > MAX_M)
        begin
            cfg_min = MAX_M;
        end
        else
        begin
            cfg_min = cfg_data;
        end
        cfg_total = MS_W'(cfg_min) * itw_pkg::MS_PER_MINUTE;
        cfg_warn  = (WARN_V >= cfg_total) ? {1'b0, cfg_total[MS_W-1:1]} : WARN_V;
        total_next  = cfg_write ? cfg_total : total_reg;
        thresh_next = cfg_write ? (cfg_total - cfg_warn) : thresh_reg;
    end

    // Watchdog pass on the registered item.
    logic [NOW_W-1:0]                base;
    logic [NOW_W-1:0]                elapsed;
    logic [MS_W-1:0]                 diff;
    logic [itw_pkg::DIV_IN_W-1:0]    div_in;
    logic [itw_pkg::DIV_PROD_W-1:0]  div_prod;
    logic [itw_pkg::DIV_Q_W-1:0]     div_q;
    logic [SHOWN_W-1:0]              secs;

    always_comb
    begin
        base     = (s1_data_reg.activity || !seeded_reg) ? s1_data_reg.now_ms : last_act_reg;
        elapsed  = s1_data_reg.now_ms - base;
        diff     = total_reg - elapsed[MS_W-1:0];
        div_in   = diff[itw_pkg::DIV_IN_W-1:0] + itw_pkg::ROUND_UP;
        div_prod = itw_pkg::DIV_PROD_W'(div_in) * itw_pkg::DIV_PROD_W'(itw_pkg::DIV_RECIP);
        div_q    = div_prod[itw_pkg::DIV_PROD_W-1:itw_pkg::DIV_SHIFT];
        secs     = (div_q > itw_pkg::DIV_Q_W'(itw_pkg::SECS_CAP))
                   ? itw_pkg::SECS_CAP : div_q[SHOWN_W-1:0];
    end

    // Next state and result.
    always_comb
    begin
        last_act_next = last_act_reg;
        seeded_next   = seeded_reg;
        showing_next  = showing_reg;
        shown_next    = shown_reg;
        res_data_next = res_data_reg;

        if (cfg_write)
        begin
            seeded_next = 1'b0;
            shown_next  = itw_pkg::NO_SECONDS;
        end
        else if (process)
        begin
            res_data_next.event_res    = itw_pkg::EV_NONE;
            res_data_next.seconds_left = '0;
            res_data_next.flash_invert = 1'b0;
            res_data_next.time_left_ms = '0;
            res_data_next.window_ms    = total_reg;
            res_data_next.status_valid = 1'b0;
            seeded_next   = 1'b1;
            last_act_next = base;

            if (!s1_data_reg.scene_active)
            begin
                // Timing paused: drop any countdown, baseline follows the clock.
                if (showing_reg)
                begin
                    res_data_next.event_res = itw_pkg::EV_CLEAR;
                    showing_next = 1'b0;
                    shown_next   = itw_pkg::NO_SECONDS;
                end
                last_act_next = s1_data_reg.now_ms;
            end
            else if (elapsed >= NOW_W'(total_reg))
            begin
                // Timeout reached: power off and restart the window.
                res_data_next.event_res = itw_pkg::EV_OFF;
                showing_next  = 1'b0;
                shown_next    = itw_pkg::NO_SECONDS;
                last_act_next = s1_data_reg.now_ms;
            end
            else
            begin
                res_data_next.status_valid = 1'b1;
                res_data_next.time_left_ms = diff;
                if (elapsed < NOW_W'(thresh_reg))
                begin
                    // Outside the warning window.
                    if (showing_reg)
                    begin
                        res_data_next.event_res = itw_pkg::EV_CLEAR;
                        showing_next = 1'b0;
                        shown_next   = itw_pkg::NO_SECONDS;
                    end
                end
                else if (secs != shown_reg)
                begin
                    // Inside the window: redraw only when the seconds change.
                    res_data_next.event_res    = itw_pkg::EV_SHOW;
                    res_data_next.seconds_left = secs[itw_pkg::SECS_W-1:0];
                    res_data_next.flash_invert = secs[0];
                    showing_next = 1'b1;
                    shown_next   = secs;
                end
            end
        end

        s1_valid_next  = load_in ? item_valid : s1_valid_reg;
        s1_data_next   = (load_in && item_valid) ? item : s1_data_reg;
        res_valid_next = advance ? s1_valid_reg : res_valid_reg;
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= RESET_TOTAL;
            thresh_reg    <= RESET_THRESH;
            last_act_reg  <= '0;
            seeded_reg    <= 1'b0;
            showing_reg   <= 1'b0;
            shown_reg     <= itw_pkg::NO_SECONDS;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            thresh_reg    <= thresh_next;
            last_act_reg  <= last_act_next;
            seeded_reg    <= seeded_next;
            showing_reg   <= showing_next;
            shown_reg     <= shown_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        s1_data_reg  <= s1_data_next;
        res_data_reg <= res_data_next;
    end

`ifndef NO_ASSERTIONS
    // A remembered count is always a displayable value.
    a_shown_range: assert property (@(posedge clk) disable iff (!rst_n)
        (shown_reg != itw_pkg::NO_SECONDS) |-> (shown_reg <= itw_pkg::SECS_CAP))
        else $error("last shown seconds out of range");

    // A countdown result carries a nonzero count, its flash bit and valid status.
    a_show_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_data_reg.event_res == itw_pkg::EV_SHOW) |->
        (res_data_reg.status_valid && res_data_reg.seconds_left != '0 &&
         res_data_reg.flash_invert == res_data_reg.seconds_left[0]))
        else $error("countdown result fields inconsistent");

    // Power-off leaves nothing remaining and no valid status.
    a_off_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_data_reg.event_res == itw_pkg::EV_OFF) |->
        (!res_data_reg.status_valid && res_data_reg.time_left_ms == '0))
        else $error("power-off result fields inconsistent");

    // Remaining time never exceeds the configured total.
    a_remaining_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_data_reg.time_left_ms <= res_data_reg.window_ms))
        else $error("remaining time exceeds total");
`endif

endmodule
